@@ hw/rtl/agc_pkg.sv @@
// accel gesture classifier package: face codes, register indexes, widths and
// the structs passed between the top level, the axis lanes and the merge stage
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package agc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int THR_W     = 16;
    localparam int FRAME_W   = 6;
    localparam int FACE_IN_W = 4;
    localparam int FACE_W    = 3;
    localparam int MOTION_W  = SAMPLE_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int NUM_AXES  = 3;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // output face codes
    localparam logic [FACE_W-1:0] GEST_IDLE    = 3'd0;
    localparam logic [FACE_W-1:0] GEST_SHAKE   = 3'd1;
    localparam logic [FACE_W-1:0] GEST_TILT_L  = 3'd2;
    localparam logic [FACE_W-1:0] GEST_TILT_R  = 3'd3;
    localparam logic [FACE_W-1:0] GEST_LOOK_UP = 3'd4;
    localparam logic [FACE_W-1:0] GEST_LOOK_DN = 3'd5;
    localparam logic [FACE_W-1:0] GEST_FLAT    = 3'd6;
    localparam logic [FACE_W-1:0] GEST_HAPPY   = 3'd7;

    // manual faces shown by the host
    localparam logic [FACE_IN_W-1:0] MAN_LISTEN = 4'd8;
    localparam logic [FACE_IN_W-1:0] MAN_THINK  = 4'd9;
    localparam logic [FACE_IN_W-1:0] MAN_TALK   = 4'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_LAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_LOCK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_HOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_HOLD = 3'd6;

    // register reset values
    localparam logic [THR_W-1:0]   RST_TILT_THR     = 16'd1500;
    localparam logic [THR_W-1:0]   RST_SHAKE_THR    = 16'd4500;
    localparam logic [THR_W-1:0]   RST_FLAT_THR     = 16'd4500;
    localparam logic [THR_W-1:0]   RST_FLAT_LAT     = 16'd4500;
    localparam logic [FRAME_W-1:0] RST_SHAKE_LOCK   = 6'd16;
    localparam logic [FRAME_W-1:0] RST_SHAKE_HOLD   = 6'd18;
    localparam logic [FRAME_W-1:0] RST_GESTURE_HOLD = 6'd10;

    typedef struct packed {
        logic [THR_W-1:0]   tilt_thr;
        logic [THR_W-1:0]   shake_thr;
        logic [THR_W-1:0]   flat_thr;
        logic [THR_W-1:0]   flat_lat;
        logic [FRAME_W-1:0] shake_lock;
        logic [FRAME_W-1:0] shake_hold;
        logic [FRAME_W-1:0] gesture_hold;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic cal;
        logic div_start;
    } t_lane_ctl;

    typedef struct packed {
        logic                pos;
        logic [SAMPLE_W-1:0] ad;
        logic [SAMPLE_W-1:0] mt;
    } t_lane_res;

endpackage

`default_nettype wire

@@ hw/rtl/accel_gesture_classifier.sv @@
// top level of the accelerometer gesture classifier: handshakes, register
// file, calibration control, three axis lanes and the merge stage
// depends on agc_pkg, agc_lane, agc_merge
//
//  channel   direction  handshake                 payload
//  sample    in         i_in_valid / o_in_stall   i_accel_x/y/z, i_current_face
//  result    out        o_out_valid / i_out_stall o_next_face, o_write_face, o_calibrating
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one sample per cycle while the input is not stalled; a result passes the lane stage, then the merge register
// after the last baseline sample the input stalls while each lane's
// divider forms the baseline (start, reciprocal multiply, baseline load)
// reset clears calibration, counters and valid flags and loads the register defaults
// a stalled output holds its beat; one more sample is still taken into the lane stage
`timescale 1ns / 1ps
`default_nettype none

module accel_gesture_classifier #(
    parameter int CAL_SAMPLES = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0]    i_accel_x,
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0]    i_accel_y,
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0]    i_accel_z,
    input  wire logic [agc_pkg::FACE_IN_W-1:0]          i_current_face,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [agc_pkg::FACE_W-1:0]                  o_next_face,
    output logic                                        o_write_face,
    output logic                                        o_calibrating,
    input  wire logic                                   i_cfg_we,
    input  wire logic [agc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [agc_pkg::CFG_W-1:0]              i_cfg_data
);
    import agc_pkg::*;

    localparam int CAL_CNT_W = $clog2(CAL_SAMPLES + 1);

    t_cfg                 r_cfg;
    logic                 r_s1_valid;
    logic                 r_s1_cal;
    logic [FACE_IN_W-1:0] r_s1_face;
    logic [CAL_CNT_W-1:0] r_cal_cnt;
    logic                 r_div_start;

    logic                       accept;
    logic                       in_cal;
    logic                       move;
    logic                       s1_free;
    logic [NUM_AXES-1:0]        lane_busy;
    t_lane_ctl                  lane_ctl;
    t_lane_res                  lane_res [NUM_AXES];
    logic signed [SAMPLE_W-1:0] sample [NUM_AXES];

    assign sample[AXIS_X] = i_accel_x;
    assign sample[AXIS_Y] = i_accel_y;
    assign sample[AXIS_Z] = i_accel_z;

    assign in_cal     = (r_cal_cnt < CAL_CNT_W'(CAL_SAMPLES));
    assign s1_free    = !r_s1_valid || move;
    assign o_in_stall = !s1_free || r_div_start || (|lane_busy);
    assign accept     = i_in_valid && !o_in_stall;

    assign lane_ctl.accept    = accept;
    assign lane_ctl.cal       = in_cal;
    assign lane_ctl.div_start = r_div_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_thr     <= RST_TILT_THR;
            r_cfg.shake_thr    <= RST_SHAKE_THR;
            r_cfg.flat_thr     <= RST_FLAT_THR;
            r_cfg.flat_lat     <= RST_FLAT_LAT;
            r_cfg.shake_lock   <= RST_SHAKE_LOCK;
            r_cfg.shake_hold   <= RST_SHAKE_HOLD;
            r_cfg.gesture_hold <= RST_GESTURE_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TILT_THR:     r_cfg.tilt_thr     <= i_cfg_data[THR_W-1:0];
                CFG_SHAKE_THR:    r_cfg.shake_thr    <= i_cfg_data[THR_W-1:0];
                CFG_FLAT_THR:     r_cfg.flat_thr     <= i_cfg_data[THR_W-1:0];
                CFG_FLAT_LAT:     r_cfg.flat_lat     <= i_cfg_data[THR_W-1:0];
                CFG_SHAKE_LOCK:   r_cfg.shake_lock   <= i_cfg_data[FRAME_W-1:0];
                CFG_SHAKE_HOLD:   r_cfg.shake_hold   <= i_cfg_data[FRAME_W-1:0];
                CFG_GESTURE_HOLD: r_cfg.gesture_hold <= i_cfg_data[FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_cal_cnt   <= '0;
            r_div_start <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            // last baseline beat kicks off the lane dividers
            r_div_start <= accept && in_cal && (r_cal_cnt == CAL_CNT_W'(CAL_SAMPLES - 1));
            if (accept && in_cal) begin
                r_cal_cnt <= r_cal_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cal  <= in_cal;
            r_s1_face <= i_current_face;
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        agc_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_sample (sample[g]),
            .o_busy   (lane_busy[g]),
            .o_res    (lane_res[g])
        );
    end

    agc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_s1_valid    (r_s1_valid),
        .i_s1_cal      (r_s1_cal),
        .i_s1_face     (r_s1_face),
        .i_lane        (lane_res),
        .i_out_stall   (i_out_stall),
        .o_move        (move),
        .o_out_valid   (o_out_valid),
        .o_next_face   (o_next_face),
        .o_write_face  (o_write_face),
        .o_calibrating (o_calibrating)
    );

`ifndef NO_ASSERTIONS
    a_cal_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_cnt <= CAL_CNT_W'(CAL_SAMPLES))
        else $error("calibration count overran");
    a_div_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |=> (lane_busy == {NUM_AXES{1'b1}}))
        else $error("lane dividers not running after start");
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_busy == '0) || (lane_busy == {NUM_AXES{1'b1}}))
        else $error("lane dividers out of step");
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted beat lost before the merge stage");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/agc_div.sv @@
// divider by a constant for the baseline: magnitude, reciprocal multiply and
// shift, then the sign restored; truncates toward zero
// depends on agc_pkg
`timescale 1ns / 1ps
`default_nettype none

module agc_div #(
    parameter int DVD_W   = 20,
    parameter int DIVISOR = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [DVD_W-1:0]             i_dividend,
    output logic                                     o_busy,
    output logic                                     o_done,
    output logic signed [agc_pkg::SAMPLE_W-1:0]      o_quot
);
    import agc_pkg::*;

    // floor(n * RECIP / 2^SHIFT) equals floor(n / DIVISOR) for every n below 2^DVD_W
    localparam int     SHIFT   = DVD_W + $clog2(DIVISOR);
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                 / longint'(DIVISOR);
    localparam logic [DVD_W:0] RECIP = (DVD_W + 1)'(RECIP_L);
    localparam int     PROD_W  = 2 * DVD_W + 1;

    logic [DVD_W-1:0]    r_mag;
    logic                r_neg;
    logic                r_busy;
    logic                r_done;
    logic [SAMPLE_W-1:0] r_quot;

    logic [DVD_W-1:0]    dvd_u;
    logic [DVD_W-1:0]    dvd_mag;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] quot_u;

    assign dvd_u   = i_dividend;
    assign dvd_mag = dvd_u[DVD_W-1] ? (~dvd_u + 1'b1) : dvd_u;
    assign prod    = PROD_W'(r_mag) * PROD_W'(RECIP);

    // quotient magnitude never exceeds 2^15
    assign quot_u  = prod[SHIFT +: SAMPLE_W];
    assign o_quot  = signed'(r_quot);
    assign o_busy  = r_busy;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= dvd_mag;
            r_neg <= dvd_u[DVD_W-1];
        end
        if (r_busy) begin
            r_quot <= r_neg ? (~quot_u + 1'b1) : quot_u;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("divider done without a running division");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/agc_lane.sv @@
// one axis lane: baseline accumulation and division, delta from baseline,
// change from the previous sample; results registered for the merge stage
// depends on agc_pkg and agc_div
`timescale 1ns / 1ps
`default_nettype none

module agc_lane #(
    parameter int CAL_SAMPLES = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire agc_pkg::t_lane_ctl                     i_ctl,
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                        o_busy,
    output agc_pkg::t_lane_res                          o_res
);
    import agc_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(CAL_SAMPLES);

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_base;
    logic signed [SAMPLE_W-1:0] r_prev;
    t_lane_res                  r_res;

    logic                       div_busy;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_quot;

    logic signed [SAMPLE_W:0] d;
    logic signed [SAMPLE_W:0] m;
    logic [SAMPLE_W:0]        d_u;
    logic [SAMPLE_W:0]        m_u;
    logic [SAMPLE_W:0]        ad_full;
    logic [SAMPLE_W:0]        mt_full;
    t_lane_res                n_res;

    agc_div #(
        .DVD_W   (SUM_W),
        .DIVISOR (CAL_SAMPLES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (r_sum),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        d       = (SAMPLE_W + 1)'(i_sample) - (SAMPLE_W + 1)'(r_base);
        m       = (SAMPLE_W + 1)'(i_sample) - (SAMPLE_W + 1)'(r_prev);
        d_u     = d;
        m_u     = m;
        ad_full = d_u[SAMPLE_W] ? (~d_u + 1'b1) : d_u;
        mt_full = m_u[SAMPLE_W] ? (~m_u + 1'b1) : m_u;
        // magnitudes of 17-bit differences of 16-bit values fit in 16 bits
        n_res.ad  = ad_full[SAMPLE_W-1:0];
        n_res.mt  = mt_full[SAMPLE_W-1:0];
        n_res.pos = !d_u[SAMPLE_W] && (d_u != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_base <= '0;
            r_prev <= '0;
        end else begin
            if (i_ctl.accept && i_ctl.cal) begin
                r_sum <= r_sum + SUM_W'(i_sample);
            end
            if (i_ctl.accept && !i_ctl.cal) begin
                r_prev <= i_sample;
            end
            if (div_done) begin
                r_base <= div_quot;
                r_prev <= div_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_res <= n_res;
        end
    end

    assign o_busy = div_busy | div_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/agc_merge.sv @@
// merge stage: motion sum, gesture priority, shake and hold counters, face
// decision and the output register
// depends on agc_pkg
`timescale 1ns / 1ps
`default_nettype none

module agc_merge (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire agc_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_s1_valid,
    input  wire logic                               i_s1_cal,
    input  wire logic [agc_pkg::FACE_IN_W-1:0]      i_s1_face,
    input  wire agc_pkg::t_lane_res                 i_lane [agc_pkg::NUM_AXES],
    input  wire logic                               i_out_stall,
    output logic                                    o_move,
    output logic                                    o_out_valid,
    output logic [agc_pkg::FACE_W-1:0]              o_next_face,
    output logic                                    o_write_face,
    output logic                                    o_calibrating
);
    import agc_pkg::*;

    logic               r_out_valid;
    logic [FACE_W-1:0]  r_next_face;
    logic               r_write_face;
    logic               r_calibrating;
    logic [FRAME_W-1:0] r_shake_cnt;
    logic [FRAME_W-1:0] r_hold_cnt;
    logic [FACE_W-1:0]  r_held;

    logic [MOTION_W-1:0] motion;
    logic [MOTION_W-1:0] shake3;
    logic [FACE_W-1:0]   trig;
    logic [FRAME_W-1:0]  sc_eff;
    logic [FRAME_W-1:0]  hc_eff;
    logic [FACE_W-1:0]   hf_eff;
    logic [FRAME_W-1:0]  n_shake_cnt;
    logic [FRAME_W-1:0]  n_hold_cnt;
    logic [FACE_W-1:0]   next;
    logic                manual;
    logic [FACE_W-1:0]   n_next_face;
    logic                n_write_face;
    logic                out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_move   = i_s1_valid && out_free;

    always_comb begin
        motion = MOTION_W'(i_lane[AXIS_X].mt) + MOTION_W'(i_lane[AXIS_Y].mt)
               + MOTION_W'(i_lane[AXIS_Z].mt);
        shake3 = MOTION_W'({i_cfg.shake_thr, 1'b0}) + MOTION_W'(i_cfg.shake_thr);

        trig = GEST_IDLE;
        if (motion > shake3) begin
            trig = GEST_SHAKE;
        end else if (i_lane[AXIS_X].ad > i_cfg.tilt_thr ||
                     i_lane[AXIS_Y].ad > i_cfg.tilt_thr) begin
            if (i_lane[AXIS_X].ad >= i_lane[AXIS_Y].ad) begin
                trig = i_lane[AXIS_X].pos ? GEST_TILT_R : GEST_TILT_L;
            end else begin
                trig = i_lane[AXIS_Y].pos ? GEST_LOOK_UP : GEST_LOOK_DN;
            end
        end else if (i_lane[AXIS_Z].ad > i_cfg.flat_thr &&
                     i_lane[AXIS_X].ad < i_cfg.flat_lat &&
                     i_lane[AXIS_Y].ad < i_cfg.flat_lat) begin
            trig = GEST_FLAT;
        end else if (motion > MOTION_W'(i_cfg.shake_thr)) begin
            trig = GEST_HAPPY;
        end

        // counters as loaded by this frame's gesture, before countdown
        sc_eff = (trig == GEST_SHAKE) ? i_cfg.shake_lock : r_shake_cnt;
        hc_eff = r_hold_cnt;
        hf_eff = r_held;
        if (trig != GEST_IDLE) begin
            hf_eff = trig;
            hc_eff = (trig == GEST_SHAKE) ? i_cfg.shake_hold : i_cfg.gesture_hold;
        end

        manual = (i_s1_face == MAN_LISTEN) || (i_s1_face == MAN_THINK) ||
                 (i_s1_face == MAN_TALK);

        next        = GEST_IDLE;
        n_shake_cnt = sc_eff;
        n_hold_cnt  = hc_eff;
        if (sc_eff != '0) begin
            next        = GEST_SHAKE;
            n_shake_cnt = sc_eff - 1'b1;
        end else if (hc_eff != '0) begin
            next       = hf_eff;
            n_hold_cnt = hc_eff - 1'b1;
        end

        // manual faces freeze the countdown and report idle
        if (manual) begin
            n_shake_cnt  = sc_eff;
            n_hold_cnt   = hc_eff;
            n_next_face  = GEST_IDLE;
            n_write_face = 1'b0;
        end else begin
            n_next_face  = next;
            n_write_face = ({1'b0, next} != i_s1_face);
        end

        if (i_s1_cal) begin
            n_next_face  = GEST_IDLE;
            n_write_face = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_shake_cnt <= '0;
            r_hold_cnt  <= '0;
            r_held      <= GEST_IDLE;
        end else begin
            if (o_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_move && !i_s1_cal) begin
                r_shake_cnt <= n_shake_cnt;
                r_hold_cnt  <= n_hold_cnt;
                r_held      <= hf_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_next_face   <= n_next_face;
            r_write_face  <= n_write_face;
            r_calibrating <= i_s1_cal;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_face   = r_next_face;
    assign o_write_face  = r_write_face;
    assign o_calibrating = r_calibrating;

`ifndef NO_ASSERTIONS
    a_cal_beat_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_calibrating) |-> (r_next_face == GEST_IDLE && !r_write_face))
        else $error("calibration beat carries a face");
    a_cal_keeps_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_move && i_s1_cal) |=> ($stable(r_shake_cnt) && $stable(r_hold_cnt)))
        else $error("calibration beat changed hold counters");
    a_shake_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_move && !i_s1_cal && !manual && sc_eff != '0) |=> (r_next_face == GEST_SHAKE))
        else $error("shake lock not reflected in face");
`endif

endmodule

`default_nettype wire
